// ===== rtl/dsl_pkg.sv =====
// Shared types, codes and arithmetic helpers for the dense sigmoid layer.
// Holds the sigmoid lookup table built at elaboration; no dependencies.
package dsl_pkg;

    localparam int MAX_INPUTS      = 64;
    localparam int MAX_OUTPUTS     = 16;
    localparam int SIGMOID_ENTRIES = 256;
    localparam int ROW_W           = $clog2(MAX_OUTPUTS);
    localparam int COL_W           = $clog2(MAX_INPUTS);
    localparam int NIN_W           = COL_W + 1;
    localparam int NOUT_W          = ROW_W + 1;
    localparam int ADDR_W          = ROW_W + COL_W;
    localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);
    localparam int SIG_STEP        = (16 * 65536) / SIGMOID_ENTRIES;
    localparam int SIG_SHIFT       = $clog2(SIG_STEP);
    localparam int SIG_W           = 17;

    localparam logic [6:0]  INPUT_COUNT_RESET   = 7'd64;
    localparam logic [4:0]  OUTPUT_COUNT_RESET  = 5'd16;
    localparam logic [16:0] LEARNING_RATE_RESET = 17'd6554;

    localparam logic [1:0] CFG_INPUT_COUNT   = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_COUNT  = 2'd1;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd2;

    localparam logic [1:0] KIND_ACTIVATION = 2'd0;
    localparam logic [1:0] KIND_DELTA      = 2'd1;
    localparam logic [1:0] KIND_WEIGHT     = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD_WEIGHT = 3'd0,
        OP_LOAD_BIAS   = 3'd1,
        OP_FORWARD     = 3'd2,
        OP_BACKWARD    = 3'd3,
        OP_PRIOR_ACT   = 3'd4,
        OP_UPDATE      = 3'd5,
        OP_READ_WEIGHT = 3'd6,
        OP_NONE        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        MUL_FWD   = 3'd0,  // weight * input
        MUL_BWD   = 3'd1,  // next weight * next delta
        MUL_DERIV = 3'd2,  // s * (1 - s)
        MUL_DELTA = 3'd3,  // backprop sum * derivative
        MUL_LRD   = 3'd4,  // rate * delta
        MUL_GRAD  = 3'd5,  // delta * prior activation
        MUL_LRG   = 3'd6   // rate * gradient
    } mul_sel_t;

    typedef enum logic [1:0] {
        RD_ITEM = 2'd0,
        RD_FWD  = 2'd1,
        RD_UPD  = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic             capture;
        logic             wr_weight;
        logic             wr_bias;
        logic             wr_prior;
        logic             restart;
        logic             mem_rd;
        rd_src_t          rd_src;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             acc_fwd;
        logic             acc_bwd;
        logic             bias_upd;
        logic             weight_upd;
        logic             act_emit;
        logic             delta_emit;
        logic             rd_emit;
        logic             emit_end;
        logic [ROW_W-1:0] i;
        logic [COL_W-1:0] j;
    } dsl_cmd_t;

    typedef struct packed {
        op_t               op;
        logic              last;
        logic              col_in_use;
        logic              row_in_use;
        logic [NIN_W-1:0]  n_in;
        logic [NOUT_W-1:0] n_out;
        logic              out_free;
    } dsl_status_t;

    typedef logic [SIGMOID_ENTRIES-1:0][SIG_W-1:0] sig_tab_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sh7fffffff)
            r = 32'sh7fffffff;
        else if (v < -50'sh80000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Round half up, floor shift by 16, saturate.
    function automatic logic signed [31:0] q_round(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = p + 66'sd32768;
        return sat32(r[65:16]);
    endfunction

    function automatic logic [SIG_IDX_W-1:0] sig_index(input logic signed [31:0] z);
        logic signed [33:0] off;
        logic [33:0]        idx;
        logic [SIG_IDX_W-1:0] r;
        off = 34'(z) + 34'sd524288;
        idx = 34'(off) >> SIG_SHIFT;
        if (off < 0)
            r = '0;
        else if (idx >= 34'(SIGMOID_ENTRIES))
            r = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
        else
            r = idx[SIG_IDX_W-1:0];
        return r;
    endfunction

    // Shift-subtract quotient, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [SIG_W-1:0] sig_eval(input longint x);
        logic [63:0] t;
        logic [63:0] one;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] res;
        t   = (x < 0) ? 64'(-x) : 64'(x);
        one = 64'd1 << 31;
        if (t > 64'd524288)
            t = 64'd524288;
        u  = t << 7;
        u2 = (u * u) >> 31;
        u3 = (u2 * u) >> 31;
        u4 = (u3 * u) >> 31;
        e  = one - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
        for (int k = 0; k < 8; k++)
            e = (e * e) >> 31;
        den = one + e;
        num = (x < 0) ? e : one;
        res = udiv64((num << 16) + (den >> 1), den);
        return res[SIG_W-1:0];
    endfunction

    function automatic sig_tab_t build_sig_table();
        sig_tab_t tab;
        longint   x;
        for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
            x = -longint'(524288) + longint'(k) * SIG_STEP + SIG_STEP / 2;
            tab[k] = sig_eval(x);
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/dsl_ctrl.sv =====
// Sequencer for the dense sigmoid layer: one-hot state machine and loop counters.
// Depends on dsl_pkg; drives the datapath through dsl_cmd_t only.
module dsl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dsl_pkg::dsl_status_t status,
    output dsl_pkg::dsl_cmd_t    cmd
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_DISP  = 18'b000000000000000010,
        S_FRD   = 18'b000000000000000100,
        S_FMUL  = 18'b000000000000001000,
        S_FACC  = 18'b000000000000010000,
        S_ACT   = 18'b000000000000100000,
        S_BMUL  = 18'b000000000001000000,
        S_BACC  = 18'b000000000010000000,
        S_DMUL1 = 18'b000000000100000000,
        S_DMUL2 = 18'b000000001000000000,
        S_DEMIT = 18'b000000010000000000,
        S_UB1   = 18'b000000100000000000,
        S_UB2   = 18'b000001000000000000,
        S_URD   = 18'b000010000000000000,
        S_UG    = 18'b000100000000000000,
        S_ULG   = 18'b001000000000000000,
        S_UWR   = 18'b010000000000000000,
        S_REMIT = 18'b100000000000000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [dsl_pkg::ROW_W-1:0]  i_reg, i_next;
    logic [dsl_pkg::COL_W-1:0]  j_reg, j_next;
    logic                       i_last;
    logic                       j_last;
    logic                       no_zero;

    assign i_last  = (dsl_pkg::NOUT_W'(i_reg) + 1'b1) == status.n_out;
    assign j_last  = (dsl_pkg::NIN_W'(j_reg) + 1'b1) == status.n_in;
    assign no_zero = (status.n_out == '0);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.rd_src  = dsl_pkg::RD_ITEM;
        cmd.mul_sel = dsl_pkg::MUL_FWD;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.emit_end = i_last;
        unique case (state_reg)
            S_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                unique case (status.op)
                    dsl_pkg::OP_LOAD_WEIGHT: cmd.wr_weight = 1'b1;
                    dsl_pkg::OP_LOAD_BIAS:   cmd.wr_bias   = 1'b1;
                    dsl_pkg::OP_PRIOR_ACT:   cmd.wr_prior  = 1'b1;
                    dsl_pkg::OP_FORWARD:
                    begin
                        cmd.restart = 1'b1;
                        if (status.col_in_use && !no_zero)
                            state_next = S_FRD;
                        else if (status.last && !no_zero)
                            state_next = S_ACT;
                    end
                    dsl_pkg::OP_BACKWARD:
                    begin
                        if (status.row_in_use)
                            state_next = S_BMUL;
                        else if (status.last && !no_zero)
                            state_next = S_DMUL1;
                    end
                    dsl_pkg::OP_UPDATE:
                    begin
                        if (!no_zero)
                            state_next = S_UB1;
                    end
                    dsl_pkg::OP_READ_WEIGHT:
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rd_src = dsl_pkg::RD_ITEM;
                        state_next = S_REMIT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_FRD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_src = dsl_pkg::RD_FWD;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_FWD;
                state_next  = S_FACC;
            end
            S_FACC:
            begin
                cmd.acc_fwd = 1'b1;
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = status.last ? S_ACT : S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_ACT:
            begin
                if (status.out_free)
                begin
                    cmd.act_emit = 1'b1;
                    i_next       = i_reg + 1'b1;
                    if (i_last)
                        state_next = S_IDLE;
                end
            end
            S_BMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_BWD;
                state_next  = S_BACC;
            end
            S_BACC:
            begin
                cmd.acc_bwd = 1'b1;
                state_next  = status.last ? S_DMUL1 : S_IDLE;
            end
            S_DMUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_DERIV;
                state_next  = S_DMUL2;
            end
            S_DMUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_DELTA;
                state_next  = S_DEMIT;
            end
            S_DEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.delta_emit = 1'b1;
                    i_next         = i_reg + 1'b1;
                    state_next     = i_last ? S_IDLE : S_DMUL1;
                end
            end
            S_UB1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_LRD;
                state_next  = S_UB2;
            end
            S_UB2:
            begin
                cmd.bias_upd = 1'b1;
                j_next       = '0;
                if (status.n_in != '0)
                    state_next = S_URD;
                else if (i_last)
                    state_next = S_IDLE;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_UB1;
                end
            end
            S_URD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_src = dsl_pkg::RD_UPD;
                state_next = S_UG;
            end
            S_UG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_GRAD;
                state_next  = S_ULG;
            end
            S_ULG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsl_pkg::MUL_LRG;
                state_next  = S_UWR;
            end
            S_UWR:
            begin
                cmd.weight_upd = 1'b1;
                if (!j_last)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_URD;
                end
                else if (i_last)
                    state_next = S_IDLE;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_UB1;
                end
            end
            S_REMIT:
            begin
                cmd.emit_end = 1'b1;
                if (status.out_free)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

// ===== rtl/dsl_datapath.sv =====
// Datapath for the dense sigmoid layer: item latch, settings, weight memory,
// neuron state, shared multiplier and output register. Depends on dsl_pkg.
module dsl_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsl_pkg::dsl_cmd_t    cmd,
    output dsl_pkg::dsl_status_t status,
    input  logic [2:0]           in_op,
    input  logic [3:0]           in_row,
    input  logic [5:0]           in_col,
    input  logic signed [31:0]   in_value,
    input  logic signed [31:0]   in_value2,
    input  logic                 in_last,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [16:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_kind,
    output logic [5:0]           out_index,
    output logic signed [31:0]   out_value,
    output logic                 out_end
);

    localparam int NO = dsl_pkg::MAX_OUTPUTS;
    localparam int NI = dsl_pkg::MAX_INPUTS;

    logic [2:0]                 op_reg;
    logic [dsl_pkg::ROW_W-1:0]  row_reg;
    logic [dsl_pkg::COL_W-1:0]  col_reg;
    logic signed [31:0]         val_reg;
    logic signed [31:0]         val2_reg;
    logic                       last_reg;

    logic [6:0]                 in_count_reg;
    logic [4:0]                 out_count_reg;
    logic [16:0]                lr_reg;
    logic [dsl_pkg::NIN_W-1:0]  n_in;
    logic [dsl_pkg::NOUT_W-1:0] n_out;

    logic signed [31:0]         weight_mem [0:NO*NI-1];
    logic signed [31:0]         rdata_reg;
    logic [dsl_pkg::ADDR_W-1:0] raddr;
    logic [dsl_pkg::ADDR_W-1:0] waddr;
    logic signed [31:0]         wdata;
    logic                       we;

    logic signed [31:0]         bias_reg  [0:NO-1];
    logic signed [31:0]         pre_reg   [0:NO-1];
    logic signed [31:0]         bp_reg    [0:NO-1];
    logic signed [31:0]         delta_reg [0:NO-1];

    // Prior activations live in a memory; a written flag per entry makes
    // entries not yet written since reset read as zero.
    logic signed [31:0]         prior_mem [0:NI-1];
    logic [NI-1:0]              prior_vld_reg;
    logic signed [31:0]         prior_rdata_reg;

    logic signed [32:0]         mul_a;
    logic signed [32:0]         mul_b;
    logic signed [65:0]         mul_reg;
    logic signed [31:0]         q_mul;
    logic [dsl_pkg::SIG_W-1:0]  sig_val;
    logic signed [31:0]         bp_base;
    logic                       out_valid_reg;

    // Clamp the counts to what the storage holds.
    assign n_in  = (in_count_reg > 7'(NI)) ? dsl_pkg::NIN_W'(NI) : in_count_reg;
    assign n_out = (out_count_reg > 5'(NO)) ? dsl_pkg::NOUT_W'(NO) : out_count_reg;

    assign status.op         = dsl_pkg::op_t'(op_reg);
    assign status.last       = last_reg;
    assign status.col_in_use = dsl_pkg::NIN_W'(col_reg) < n_in;
    assign status.row_in_use = dsl_pkg::NOUT_W'(row_reg) < n_out;
    assign status.n_in       = n_in;
    assign status.n_out      = n_out;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign q_mul   = dsl_pkg::q_round(mul_reg);
    assign sig_val = dsl_pkg::SIG_TABLE[dsl_pkg::sig_index(pre_reg[cmd.i])];
    assign bp_base = (col_reg == '0) ? 32'sd0 : bp_reg[row_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= dsl_pkg::INPUT_COUNT_RESET;
            out_count_reg <= dsl_pkg::OUTPUT_COUNT_RESET;
            lr_reg        <= dsl_pkg::LEARNING_RATE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dsl_pkg::CFG_INPUT_COUNT)
                in_count_reg <= cfg_data[6:0];
            else if (cfg_index == dsl_pkg::CFG_OUTPUT_COUNT)
                out_count_reg <= cfg_data[4:0];
            else if (cfg_index == dsl_pkg::CFG_LEARNING_RATE)
                lr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            row_reg  <= in_row;
            col_reg  <= in_col;
            val_reg  <= in_value;
            val2_reg <= in_value2;
            last_reg <= in_last;
        end
    end

    always_comb
    begin
        unique case (cmd.rd_src)
            dsl_pkg::RD_FWD: raddr = {cmd.i, col_reg};
            dsl_pkg::RD_UPD: raddr = {cmd.i, cmd.j};
            default:         raddr = {row_reg, col_reg};
        endcase
    end

    assign we    = cmd.wr_weight || cmd.weight_upd;
    assign waddr = cmd.wr_weight ? {row_reg, col_reg} : {cmd.i, cmd.j};
    assign wdata = cmd.wr_weight ? val_reg
                 : dsl_pkg::sat32(50'(rdata_reg) - 50'(q_mul));

    always_ff @(posedge clk)
    begin
        if (we)
            weight_mem[waddr] <= wdata;
        if (cmd.mem_rd)
            rdata_reg <= weight_mem[raddr];
    end

    // Fetch the prior activation for column j beside the weight read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_prior)
            prior_mem[col_reg] <= val_reg;
        if (cmd.mem_rd)
            prior_rdata_reg <= prior_vld_reg[cmd.j] ? prior_mem[cmd.j] : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prior_vld_reg <= '0;
        else if (cmd.wr_prior)
            prior_vld_reg[col_reg] <= 1'b1;
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            dsl_pkg::MUL_FWD:
            begin
                mul_a = 33'(rdata_reg);
                mul_b = 33'(val_reg);
            end
            dsl_pkg::MUL_BWD:
            begin
                mul_a = 33'(val_reg);
                mul_b = 33'(val2_reg);
            end
            dsl_pkg::MUL_DERIV:
            begin
                mul_a = $signed({16'd0, sig_val});
                mul_b = 33'sd65536 - $signed({16'd0, sig_val});
            end
            dsl_pkg::MUL_DELTA:
            begin
                mul_a = 33'(bp_reg[cmd.i]);
                mul_b = 33'(q_mul);
            end
            dsl_pkg::MUL_LRD:
            begin
                mul_a = $signed({16'd0, lr_reg});
                mul_b = 33'(delta_reg[cmd.i]);
            end
            dsl_pkg::MUL_GRAD:
            begin
                mul_a = 33'(delta_reg[cmd.i]);
                mul_b = 33'(prior_rdata_reg);
            end
            dsl_pkg::MUL_LRG:
            begin
                mul_a = $signed({16'd0, lr_reg});
                mul_b = 33'(q_mul);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            mul_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_bias)
            bias_reg[row_reg] <= val_reg;
        else if (cmd.bias_upd)
            bias_reg[cmd.i] <= dsl_pkg::sat32(50'(bias_reg[cmd.i]) - 50'(q_mul));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NO; k++)
            begin
                pre_reg[k]   <= '0;
                bp_reg[k]    <= '0;
                delta_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.restart && col_reg == '0)
            begin
                for (int k = 0; k < NO; k++)
                    pre_reg[k] <= bias_reg[k];
            end
            if (cmd.acc_fwd)
                pre_reg[cmd.i] <= dsl_pkg::sat32(50'(pre_reg[cmd.i]) + 50'(q_mul));
            if (cmd.acc_bwd)
                bp_reg[row_reg] <= dsl_pkg::sat32(50'(bp_base) + 50'(q_mul));
            if (cmd.delta_emit)
                delta_reg[cmd.i] <= q_mul;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.act_emit || cmd.delta_emit || cmd.rd_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act_emit)
        begin
            out_kind  <= dsl_pkg::KIND_ACTIVATION;
            out_index <= 6'(cmd.i);
            out_value <= 32'($signed({15'd0, sig_val}));
            out_end   <= cmd.emit_end;
        end
        else if (cmd.delta_emit)
        begin
            out_kind  <= dsl_pkg::KIND_DELTA;
            out_index <= 6'(cmd.i);
            out_value <= q_mul;
            out_end   <= cmd.emit_end;
        end
        else if (cmd.rd_emit)
        begin
            out_kind  <= dsl_pkg::KIND_WEIGHT;
            out_index <= 6'(row_reg);
            out_value <= rdata_reg;
            out_end   <= cmd.emit_end;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/dense_sigmoid_layer_train_top.sv =====
// Top level of the dense sigmoid layer with training.
// Joins dsl_ctrl and dsl_datapath; depends on dsl_pkg.
//
// Usage:
//   Input beats arrive on s_axis_*: tuser carries the operation code, tlast
//   marks the last element of a forward or backward vector, tdata carries
//   row, col, value and value2. Results leave on m_axis_*: tuser is the kind
//   (activation, delta, weight read back), tlast marks the final result of
//   a run, tdata holds the neuron index and the Q16.16 value.
//   Settings (input count, output count, learning rate) are written through
//   cfg_we / cfg_index / cfg_data while the block is idle.
// Sequencing:
//   One beat at a time; s_axis_tready is high only between items.
//   A forward element reads, multiplies and accumulates for each neuron
//   in use in turn; a backward term multiplies and accumulates; each delta
//   multiplies for the derivative and then for the delta before it is
//   emitted; an update adjusts each bias, then reads, multiplies and writes
//   back each weight in use, all through the single shared multiplier.
// Reset and stalls:
//   Reset clears neuron state and prior activations and restores the
//   settings to 64, 16 and 6554; weights and biases hold garbage until
//   loaded. A finished result waits in the output register; the next item is
//   still taken, and emission holds only while that register is full.
module dense_sigmoid_layer_train_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // row[3:0], col[9:4], value[41:10], value2[73:42]
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // index[5:0], result_value[37:6]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    dsl_pkg::dsl_cmd_t    cmd;
    dsl_pkg::dsl_status_t status;
    logic [5:0]           out_index;
    logic signed [31:0]   out_value;

    dsl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dsl_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_row    (s_axis_tdata[3:0]),
        .in_col    (s_axis_tdata[9:4]),
        .in_value  (s_axis_tdata[41:10]),
        .in_value2 (s_axis_tdata[73:42]),
        .in_last   (s_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_index (out_index),
        .out_value (out_value),
        .out_end   (m_axis_tlast)
    );

    // Pack the result beat; the top two bits pad to whole bytes.
    assign m_axis_tdata = {2'b00, out_value, out_index};

`ifndef SYNTHESIS
    // Only one writer of the weight memory in any cycle.
    a_one_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_weight && cmd.weight_upd))
        else $error("weight memory written from two sources");

    // One result source per cycle, and only into a free output register.
    a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.act_emit, cmd.delta_emit, cmd.rd_emit}))
        else $error("two result sources at once");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.act_emit || cmd.delta_emit || cmd.rd_emit) |-> status.out_free)
        else $error("result loaded over a waiting beat");

    // An accepted item is worked on before the next one is taken.
    a_seq_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");
`endif

endmodule

// ===== sim/dsl_checker.sv =====
`timescale 1ns / 100ps
// Checker for the dense sigmoid layer: watches the input, result and settings ports,
// predicts every result in Q16.16 and compares it. Depends on dsl_pkg.
module dsl_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          pending,
    output int          errors
);

    typedef struct {
        logic [1:0]         kind;
        logic [5:0]         index;
        logic signed [31:0] value;
        logic               tail;
    } layer_result_t;

    layer_result_t results_due[$];

    logic signed [31:0] weight_mem [dsl_pkg::MAX_OUTPUTS*dsl_pkg::MAX_INPUTS];
    logic signed [31:0] bias_mem   [dsl_pkg::MAX_OUTPUTS];
    logic signed [31:0] pre_act    [dsl_pkg::MAX_OUTPUTS];
    logic signed [31:0] bp_sum     [dsl_pkg::MAX_OUTPUTS];
    logic signed [31:0] delta_mem  [dsl_pkg::MAX_OUTPUTS];
    logic signed [31:0] prior_act  [dsl_pkg::MAX_INPUTS];
    longint             logistic_lut [256];
    logic [6:0]         n_in_reg;
    logic [4:0]         n_out_reg;
    logic [16:0]        rate_reg;
    int                 mismatches;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b + 32768;
        return clamp32(p >>> 16);
    endfunction

    // e^-|x| by a short series on |x|/256, squared eight times, in Q1.31
    function automatic longint logistic_q(longint x);
        longint unsigned t;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned u3;
        longint unsigned u4;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        t = (x < 0) ? -x : x;
        if (t > 524288)
            t = 524288;
        u  = t << 7;
        u2 = (u * u) >> 31;
        u3 = (u2 * u) >> 31;
        u4 = (u3 * u) >> 31;
        e  = 64'd2147483648 - u + u2 / 2 - u3 / 6 + u4 / 24;
        for (int k = 0; k < 8; k++)
            e = (e * e) >> 31;
        den = 64'd2147483648 + e;
        num = (x < 0) ? e : 64'd2147483648;
        return longint'(((num << 16) + den / 2) / den);
    endfunction

    function automatic longint logistic_of(longint z);
        longint off;
        longint idx;
        off = z + 524288;
        if (off < 0)
            return logistic_lut[0];
        idx = off / 4096;
        if (idx > 255)
            idx = 255;
        return logistic_lut[idx];
    endfunction

    initial
    begin
        for (int k = 0; k < 256; k++)
            logistic_lut[k] = logistic_q(-longint'(524288) + k * 4096 + 2048);
    end

    function automatic void queue_result(logic [1:0] kind, int idx, longint v, bit tail);
        layer_result_t r;
        r.kind  = kind;
        r.index = idx[5:0];
        r.value = v[31:0];
        r.tail  = tail;
        results_due.push_back(r);
    endfunction

    function automatic void layer_step(dsl_pkg::op_t op, int row, int col,
                                       logic signed [31:0] val,
                                       logic signed [31:0] val2, bit last);
        int     ni;
        int     no;
        longint s;
        longint d;
        longint g;
        ni = (n_in_reg < dsl_pkg::MAX_INPUTS) ? n_in_reg : dsl_pkg::MAX_INPUTS;
        no = (n_out_reg < dsl_pkg::MAX_OUTPUTS) ? n_out_reg : dsl_pkg::MAX_OUTPUTS;
        case (op)
            dsl_pkg::OP_LOAD_WEIGHT: weight_mem[row*dsl_pkg::MAX_INPUTS+col] = val;
            dsl_pkg::OP_LOAD_BIAS:   bias_mem[row] = val;
            dsl_pkg::OP_FORWARD:
            begin
                if (col == 0)
                    for (int i = 0; i < dsl_pkg::MAX_OUTPUTS; i++)
                        pre_act[i] = bias_mem[i];
                if (col < ni)
                    for (int i = 0; i < no; i++)
                        pre_act[i] = clamp32(pre_act[i]
                                     + fx_mul(weight_mem[i*dsl_pkg::MAX_INPUTS+col], val));
                if (last)
                    for (int i = 0; i < no; i++)
                        queue_result(dsl_pkg::KIND_ACTIVATION, i, logistic_of(pre_act[i]),
                                     i == no - 1);
            end
            dsl_pkg::OP_BACKWARD:
            begin
                if (row < no)
                begin
                    if (col == 0)
                        bp_sum[row] = 0;
                    bp_sum[row] = clamp32(bp_sum[row] + fx_mul(val, val2));
                end
                if (last)
                    for (int i = 0; i < no; i++)
                    begin
                        s = logistic_of(pre_act[i]);
                        d = (s * (65536 - s) + 32768) >>> 16;
                        delta_mem[i] = fx_mul(bp_sum[i], d);
                        queue_result(dsl_pkg::KIND_DELTA, i, delta_mem[i], i == no - 1);
                    end
            end
            dsl_pkg::OP_PRIOR_ACT:   prior_act[col] = val;
            dsl_pkg::OP_UPDATE:
            begin
                for (int i = 0; i < no; i++)
                begin
                    d = delta_mem[i];
                    bias_mem[i] = clamp32(bias_mem[i] - fx_mul(longint'(rate_reg), d));
                    for (int j = 0; j < ni; j++)
                    begin
                        g = fx_mul(d, prior_act[j]);
                        weight_mem[i*dsl_pkg::MAX_INPUTS+j] =
                            clamp32(weight_mem[i*dsl_pkg::MAX_INPUTS+j]
                                    - fx_mul(longint'(rate_reg), g));
                    end
                end
            end
            dsl_pkg::OP_READ_WEIGHT:
                queue_result(dsl_pkg::KIND_WEIGHT, row,
                             weight_mem[row*dsl_pkg::MAX_INPUTS+col], 1'b1);
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        layer_result_t want;
        if (!rst_n)
        begin
            results_due.delete();
            for (int i = 0; i < dsl_pkg::MAX_OUTPUTS; i++)
            begin
                pre_act[i]   = 0;
                bp_sum[i]    = 0;
                delta_mem[i] = 0;
            end
            for (int j = 0; j < dsl_pkg::MAX_INPUTS; j++)
                prior_act[j] = 0;
            n_in_reg   = dsl_pkg::INPUT_COUNT_RESET;
            n_out_reg  = dsl_pkg::OUTPUT_COUNT_RESET;
            rate_reg   = dsl_pkg::LEARNING_RATE_RESET;
            mismatches = 0;
        end
        else
        begin
            // results first: anything leaving now belongs to an older item
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t checker: unexpected result kind %0d index %0d value %h",
                                 $realtime, m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6]);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.kind !== m_axis_tuser || want.index !== m_axis_tdata[5:0]
                        || want.value !== m_axis_tdata[37:6] || want.tail !== m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t checker: expected kind %0d index %0d value %h last %0d, got kind %0d index %0d value %h last %0d",
                                     $realtime, want.kind, want.index, want.value, want.tail,
                                     m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6],
                                     m_axis_tlast);
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    dsl_pkg::CFG_INPUT_COUNT:   n_in_reg  = cfg_data[6:0];
                    dsl_pkg::CFG_OUTPUT_COUNT:  n_out_reg = cfg_data[4:0];
                    dsl_pkg::CFG_LEARNING_RATE: rate_reg  = cfg_data;
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                layer_step(dsl_pkg::op_t'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[9:4],
                           s_axis_tdata[41:10], s_axis_tdata[73:42], s_axis_tlast);
        end
        pending <= results_due.size();
        errors  <= mismatches;
    end

endmodule

// ===== sim/tb_dense_sigmoid_layer_train_top.sv =====
`timescale 1ns / 100ps
// Testbench top for dense_sigmoid_layer_train_top: drives input beats, settings and
// result back-pressure; dsl_checker does the prediction. Depends on dsl_pkg.
module tb_dense_sigmoid_layer_train_top;

    // An update over 16 x 64 moves no beat while it runs.
    localparam int IDLE_LIMIT = 60000;
    // Covers an update still running after the last result has left.
    localparam int SETTLE     = 5000;
    // Weights are loaded for the first columns only; input counts stay at or
    // below this and random read addresses below it.
    localparam int LOADED_COLS = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // row[3:0], col[9:4], value[41:10], value2[73:42]
    logic [2:0]  s_axis_tuser;   // operation[2:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // index[5:0], result_value[37:6]
    logic [1:0]  m_axis_tuser;   // kind[1:0]
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    int          pending;
    int          errors;

    int send_idle;
    int recv_idle;
    int cur_ni;
    int cur_no;
    int stall_cycles;

    dense_sigmoid_layer_train_top i_dut (.*);
    dsl_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Randomly hold off results; the idle share changes per phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // Fail the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("tb_dense_sigmoid_layer_train_top: done, errors");
                $finish;
            end
        end
    end

    // Mostly small Q16.16 values near the sigmoid range, now and then any 32-bit word.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(32'h40000) - 32'h20000;
    endfunction

    // Hold valid across back-to-back beats; drop it only for an idle gap.
    task automatic send_item(dsl_pkg::op_t op, int row, int col, logic [31:0] val,
                             logic [31:0] val2, bit last);
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {6'd0, val2, val, col[5:0], row[3:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending, wait for every expected result, then let an update finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all three settings on consecutive edges; call only while idle.
    task automatic write_settings(int ni, int no, int rate);
        cfg_we    <= 1'b1;
        cfg_index <= dsl_pkg::CFG_INPUT_COUNT;
        cfg_data  <= 17'(ni);
        @(posedge clk);
        cfg_index <= dsl_pkg::CFG_OUTPUT_COUNT;
        cfg_data  <= 17'(no);
        @(posedge clk);
        cfg_index <= dsl_pkg::CFG_LEARNING_RATE;
        cfg_data  <= 17'(rate);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_ni = ni;
        cur_no = no;
    endtask

    // Well-formed forward / backward / update traffic with random content, plus noise.
    task automatic run_phase(int budget);
        int           sent;
        int           pick;
        int           len;
        int           nrows;
        int           terms;
        int           row;
        dsl_pkg::op_t noise_op;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                len = ($urandom_range(3) == 0) ? cur_ni
                    : $urandom_range(1, (cur_ni < 8) ? cur_ni : 8);
                for (int c = 0; c < len; c++)
                    send_item(dsl_pkg::OP_FORWARD, $urandom_range(15), c, pick_value(),
                              $urandom, c == len - 1);
                sent += len;
            end
            else if (pick < 55)
            begin
                nrows = $urandom_range(1, cur_no);
                for (int r = 0; r < nrows; r++)
                begin
                    row   = $urandom_range(cur_no - 1);
                    terms = $urandom_range(1, 3);
                    for (int t = 0; t < terms; t++)
                        send_item(dsl_pkg::OP_BACKWARD, row, t, pick_value(), pick_value(),
                                  r == nrows - 1 && t == terms - 1);
                    sent += terms;
                end
            end
            else if (pick < 65)
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    send_item(dsl_pkg::OP_PRIOR_ACT, $urandom_range(15),
                              $urandom_range(cur_ni - 1), pick_value(), $urandom,
                              $urandom_range(1));
                sent += len;
            end
            else if (pick < 73)
            begin
                send_item(dsl_pkg::OP_UPDATE, $urandom_range(15), $urandom_range(63),
                          $urandom, $urandom, $urandom_range(1));
                sent++;
            end
            else if (pick < 83)
            begin
                send_item(dsl_pkg::OP_READ_WEIGHT, $urandom_range(15),
                          $urandom_range(LOADED_COLS - 1), $urandom, $urandom,
                          $urandom_range(1));
                sent++;
            end
            else if (pick < 90)
            begin
                send_item(($urandom_range(1) != 0) ? dsl_pkg::OP_LOAD_WEIGHT
                                                   : dsl_pkg::OP_LOAD_BIAS,
                          $urandom_range(15), $urandom_range(63), pick_value(), $urandom,
                          $urandom_range(1));
                sent++;
            end
            else
            begin
                // noise: any code, any row or col, stray last flags; reads stay on
                // loaded columns
                noise_op = dsl_pkg::op_t'($urandom_range(7));
                send_item(noise_op, $urandom_range(15),
                          (noise_op == dsl_pkg::OP_READ_WEIGHT)
                              ? $urandom_range(LOADED_COLS - 1) : $urandom_range(63),
                          $urandom, $urandom, $urandom_range(1));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        stall_cycles  = 0;
        cur_ni        = 64;
        cur_no        = 16;
        send_idle     = 17;
        recv_idle     = 87;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Narrow the inputs in use to the loaded columns; the other settings keep
        // their reset values.
        cfg_we    <= 1'b1;
        cfg_index <= dsl_pkg::CFG_INPUT_COUNT;
        cfg_data  <= 17'(LOADED_COLS);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_ni = LOADED_COLS;

        // Fill every bias and the loaded weight columns so no item reads an
        // unwritten entry.
        for (int r = 0; r < dsl_pkg::MAX_OUTPUTS; r++)
            send_item(dsl_pkg::OP_LOAD_BIAS, r, 0, pick_value(), $urandom, 1'b0);
        for (int r = 0; r < dsl_pkg::MAX_OUTPUTS; r++)
            for (int c = 0; c < LOADED_COLS; c++)
                send_item(dsl_pkg::OP_LOAD_WEIGHT, r, c, pick_value(), $urandom, 1'b0);

        // Directed: extremes, every operation, stray last flags, unknown code.
        send_item(dsl_pkg::OP_NONE, 15, 63, 32'hffffffff, 32'hffffffff, 1'b1);
        send_item(dsl_pkg::OP_LOAD_WEIGHT, 15, 63, 32'h7fffffff, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_LOAD_WEIGHT, 0, 0, 32'h80000000, 32'hffffffff, 1'b0);
        send_item(dsl_pkg::OP_LOAD_BIAS, 3, 0, 32'h80000000, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_LOAD_BIAS, 15, 63, 32'h7fffffff, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_READ_WEIGHT, 15, 63, 32'h0, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_READ_WEIGHT, 0, 0, 32'hffffffff, 32'hffffffff, 1'b1);
        send_item(dsl_pkg::OP_FORWARD, 0, 0, 32'h7fffffff, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_FORWARD, 0, 5, 32'h80000000, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_FORWARD, 0, 63, 32'h00010000, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_FORWARD, 0, 0, 32'h0, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_BACKWARD, 0, 0, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_item(dsl_pkg::OP_BACKWARD, 15, 0, 32'h80000000, 32'h7fffffff, 1'b0);
        send_item(dsl_pkg::OP_BACKWARD, 15, 63, 32'h00008000, 32'h80000000, 1'b1);
        send_item(dsl_pkg::OP_PRIOR_ACT, 0, 0, 32'h7fffffff, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_PRIOR_ACT, 0, 63, 32'h80000000, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_UPDATE, 0, 0, 32'h0, 32'h0, 1'b1);
        send_item(dsl_pkg::OP_READ_WEIGHT, 0, 0, 32'h0, 32'h0, 1'b0);
        send_item(dsl_pkg::OP_READ_WEIGHT, 15, 63, 32'h0, 32'h0, 1'b0);
        run_phase(60);
        settle();

        // Smallest sizes and a zero step: out-of-use rows and cols via the noise.
        write_settings(1, 1, 0);
        run_phase(60);
        settle();

        // Swap the idle shares: slow sender, eager receiver.
        send_idle = 87;
        recv_idle = 17;
        write_settings(LOADED_COLS, 16, 65536);
        run_phase(60);
        settle();
        write_settings(5, 3, $urandom_range(65536));
        run_phase(60);
        settle();

        // Full rate on both sides.
        send_idle = 0;
        recv_idle = 0;
        write_settings(LOADED_COLS, 12, 1000);
        run_phase(60);
        settle();

        if (errors == 0)
            $display("tb_dense_sigmoid_layer_train_top: done, clean");
        else
            $display("tb_dense_sigmoid_layer_train_top: done, errors");
        $finish;
    end

endmodule
